### rtl/core/frf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frf_pkg
// Shared types and constants for the stdin record framer.
// ----------------------------------------------------------------------------
package frf_pkg;

   // record header fields
   localparam logic [7:0]  HDR_VERSION       = 8'd1;
   localparam logic [7:0]  HDR_TYPE_STDIN    = 8'd5;
   localparam int unsigned HDR_BYTES         = 8;
   localparam logic [15:0] MAX_RECORD_LENGTH = 16'hffff;
   localparam logic [15:0] RECORD_ID_RESET   = 16'd1;

   // position of a byte within one item's result sequence
   localparam logic [3:0] POS_VERSION  = 4'd0;
   localparam logic [3:0] POS_TYPE     = 4'd1;
   localparam logic [3:0] POS_ID_HI    = 4'd2;
   localparam logic [3:0] POS_ID_LO    = 4'd3;
   localparam logic [3:0] POS_LEN_HI   = 4'd4;
   localparam logic [3:0] POS_LEN_LO   = 4'd5;
   localparam logic [3:0] POS_PADDING  = 4'd6;
   localparam logic [3:0] POS_RESERVED = 4'd7;
   localparam logic [3:0] POS_DATA     = 4'd8;

   // configuration register addresses
   localparam logic [1:0] CSR_ADDR_RECORD_ID = 2'd0;

   typedef enum logic [0:0] {
      OP_DATA = 1'b0,
      OP_END  = 1'b1
   } opcode_type;

endpackage

### rtl/core/fcgi_stdin_record_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcgi_stdin_record_framer
// Wraps a byte stream into STDIN records with 8-byte headers.
// ----------------------------------------------------------------------------
// A data byte that arrives with no record open yields an 8-byte header and
// then the byte (9 output transfers); a data byte inside an open record
// yields one transfer; end of stream yields an empty-record header (8
// transfers). The output side moves one byte per cycle while the consumer
// takes them, so a byte inside a record is then taken every cycle; a byte
// that opens a record, or end of stream, holds the input until its final
// byte is loaded. An item is taken in the same cycle that the previous item's
// final byte moves to the output register, free whenever the consumer takes its byte.
module fcgi_stdin_record_framer
   import frf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [0:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_chunk_bytes_left,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_header,
   output logic        rsp_last,
   output logic        rsp_stream_done,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration
   logic [15:0] record_id_ff;

   // framing state
   logic [15:0] owed_ff, owed_in;
   logic        finished_ff, finished_in;

   // item being emitted
   logic        pend_valid_ff, pend_valid_in;
   logic [3:0]  pend_pos_ff, pend_pos_in;
   logic        pend_end_ff, pend_end_in;
   logic [15:0] pend_len_ff, pend_len_in;
   logic [7:0]  pend_data_ff, pend_data_in;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_hdr_ff, out_hdr_in;
   logic        out_last_ff, out_last_in;
   logic        out_done_ff, out_done_in;

   logic        req_xfer, out_load, pend_is_last;
   logic [15:0] open_len;
   logic [7:0]  sel_byte;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR_RECORD_ID) ? {16'd0, record_id_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         record_id_ff <= RECORD_ID_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == CSR_ADDR_RECORD_ID) begin
         record_id_ff <= csr_pwdata[15:0];
      end
   end

   // --------------------------------------------------------- byte select
   always_comb begin
      unique case (pend_pos_ff)
         POS_VERSION:  sel_byte = HDR_VERSION;
         POS_TYPE:     sel_byte = HDR_TYPE_STDIN;
         POS_ID_HI:    sel_byte = record_id_ff[15:8];
         POS_ID_LO:    sel_byte = record_id_ff[7:0];
         POS_LEN_HI:   sel_byte = pend_len_ff[15:8];
         POS_LEN_LO:   sel_byte = pend_len_ff[7:0];
         POS_PADDING:  sel_byte = 8'd0;
         POS_RESERVED: sel_byte = 8'd0;
         default:      sel_byte = pend_data_ff;
      endcase
   end

   assign pend_is_last = pend_end_ff ? (pend_pos_ff == POS_RESERVED)
                                     : (pend_pos_ff == POS_DATA);
   assign out_load     = pend_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !pend_valid_ff || (out_load && pend_is_last);
   assign req_xfer     = req_valid && req_ready;

   // record length: clamp to the maximum, and a zero count still carries this byte
   always_comb begin
      if (req_chunk_bytes_left[31:16] != 16'd0 ||
          req_chunk_bytes_left[15:0] > MAX_RECORD_LENGTH) begin
         open_len = MAX_RECORD_LENGTH;
      end else if (req_chunk_bytes_left[15:0] == 16'd0) begin
         open_len = 16'd1;
      end else begin
         open_len = req_chunk_bytes_left[15:0];
      end
   end

   // ------------------------------------------------------- next state
   always_comb begin
      owed_in       = owed_ff;
      finished_in   = finished_ff;
      pend_valid_in = pend_valid_ff;
      pend_pos_in   = pend_pos_ff;
      pend_end_in   = pend_end_ff;
      pend_len_in   = pend_len_ff;
      pend_data_in  = pend_data_ff;

      if (out_load) begin
         if (pend_is_last) begin
            pend_valid_in = 1'b0;
         end else begin
            pend_pos_in = pend_pos_ff + 4'd1;
         end
      end

      // items after the final record are dropped
      if (req_xfer && !finished_ff) begin
         pend_valid_in = 1'b1;
         pend_data_in  = req_data_byte;
         if (opcode_type'(req_opcode) == OP_END) begin
            owed_in     = 16'd0;
            finished_in = 1'b1;
            pend_end_in = 1'b1;
            pend_pos_in = POS_VERSION;
            pend_len_in = 16'd0;
         end else if (owed_ff == 16'd0) begin
            owed_in     = open_len - 16'd1;
            pend_end_in = 1'b0;
            pend_pos_in = POS_VERSION;
            pend_len_in = open_len;
         end else begin
            owed_in     = owed_ff - 16'd1;
            pend_end_in = 1'b0;
            pend_pos_in = POS_DATA;
         end
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_hdr_in   = out_hdr_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_byte_in  = sel_byte;
         out_hdr_in   = (pend_pos_ff != POS_DATA);
         out_last_in  = pend_is_last;
         out_done_in  = pend_is_last && pend_end_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff       <= 16'd0;
         finished_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         owed_ff       <= owed_in;
         finished_ff   <= finished_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_pos_ff  <= pend_pos_in;
      pend_end_ff  <= pend_end_in;
      pend_len_ff  <= pend_len_in;
      pend_data_ff <= pend_data_in;
      out_byte_ff  <= out_byte_in;
      out_hdr_ff   <= out_hdr_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_is_header   = out_hdr_ff;
   assign rsp_last        = out_last_ff;
   assign rsp_stream_done = out_done_ff;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stdin record framer.
// ----------------------------------------------------------------------------
// A short table of hand-picked items runs first. Where a row opens a record,
// it types in the header length that the row must produce. Random phases
// follow, each under a new record id that is written and read back over the
// register port while the block is idle. The run closes with an
// end-of-stream inside an open record and with items that must be ignored
// after it. Every output transfer is checked against a
// behavioral framer kept in the bench. The sender works in bursts and the
// receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb;
   import frf_pkg::*;

   localparam int IDLE_LIMIT     = 2000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int RAND_PER_PHASE = 64;
   localparam int NO_LEN         = -1;
   localparam int TABLE_ROWS     = 22;
   localparam int CLOSING_ROW    = 16;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_header;
      logic       last;
      logic       stream_done;
   } framed_byte_type;

   // hdr_len >= 0 types in the header length the row must produce
   typedef struct packed {
      opcode_type  op;
      logic [7:0]  data;
      logic [31:0] count;
      int          hdr_len;
      bit          quiet;
   } stim_row_type;

   typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_RUNS} ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [0:0]  req_opcode = OP_DATA;
   logic [7:0]  req_data_byte = 8'h00;
   logic [31:0] req_chunk_bytes_left = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_header;
   logic        rsp_last;
   logic        rsp_stream_done;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = CSR_ADDR_RECORD_ID;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // framer state as the bench sees it
   logic [15:0]     cur_req_id = RECORD_ID_RESET;
   logic [15:0]     rec_owed = 16'd0;
   bit              eos_sent = 1'b0;
   framed_byte_type framed_q[$];
   framed_byte_type head_exp;

   int             err_count = 0;
   int             burst_left = 0;
   int             idle_cycles = 0;
   ready_mode_type ready_mode = RDY_ALWAYS;
   int             mode_left = 0;
   int             hold_left = 0;

   stim_row_type stim_table [0:TABLE_ROWS-1] = '{
      '{OP_DATA, 8'h00, 32'd1,          1,      1'b0},
      '{OP_DATA, 8'hff, 32'd0,          1,      1'b0}, // zero count still opens one byte
      '{OP_DATA, 8'ha5, 32'd2,          2,      1'b0},
      '{OP_DATA, 8'h5a, 32'hffff_ffff,  NO_LEN, 1'b0},
      '{OP_DATA, 8'h01, 32'd3,          3,      1'b0},
      '{OP_DATA, 8'h80, 32'd0,          NO_LEN, 1'b0},
      '{OP_DATA, 8'h7f, 32'h8000_0000,  NO_LEN, 1'b0},
      '{OP_DATA, 8'h3c, 32'd6,          6,      1'b0},
      '{OP_DATA, 8'hc3, 32'h0001_0000,  NO_LEN, 1'b0},
      '{OP_DATA, 8'h96, 32'h0000_ffff,  NO_LEN, 1'b0},
      '{OP_DATA, 8'h69, 32'h1234_5678,  NO_LEN, 1'b0},
      '{OP_DATA, 8'h0f, 32'hffff_fffe,  NO_LEN, 1'b0},
      '{OP_DATA, 8'hf0, 32'h7fff_ffff,  NO_LEN, 1'b0},
      '{OP_DATA, 8'haa, 32'd1,          1,      1'b0},
      '{OP_DATA, 8'h55, 32'd2,          2,      1'b0},
      '{OP_DATA, 8'h11, 32'hdead_beef,  NO_LEN, 1'b0},
      // closing rows: clamp, end inside the open record, then ignored items
      '{OP_DATA, 8'hc3, 32'hffff_ffff,  65535,  1'b0},
      '{OP_DATA, 8'h00, 32'd0,          NO_LEN, 1'b0},
      '{OP_DATA, 8'hff, 32'hffff_ffff,  NO_LEN, 1'b0},
      '{OP_END,  8'h00, 32'd0,          0,      1'b0},
      '{OP_DATA, 8'h5a, 32'd1,          NO_LEN, 1'b1},
      '{OP_END,  8'hff, 32'hffff_ffff,  NO_LEN, 1'b1}
   };

   fcgi_stdin_record_framer DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_data_byte        (req_data_byte),
      .req_chunk_bytes_left (req_chunk_bytes_left),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_is_header        (rsp_is_header),
      .rsp_last             (rsp_last),
      .rsp_stream_done      (rsp_stream_done),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always #10 clock = ~clock;

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         err_count++;
      end
   endtask

   task automatic queue_header(input logic [15:0] len, input bit closing);
      logic [7:0] hdr [HDR_BYTES];
      bit         tail;
      hdr[POS_VERSION]  = HDR_VERSION;
      hdr[POS_TYPE]     = HDR_TYPE_STDIN;
      hdr[POS_ID_HI]    = cur_req_id[15:8];
      hdr[POS_ID_LO]    = cur_req_id[7:0];
      hdr[POS_LEN_HI]   = len[15:8];
      hdr[POS_LEN_LO]   = len[7:0];
      hdr[POS_PADDING]  = 8'h00;
      hdr[POS_RESERVED] = 8'h00;
      for (int i = 0; i < HDR_BYTES; i++) begin
         tail = closing && (i == HDR_BYTES - 1);
         framed_q.push_back(framed_byte_type'{hdr[i], 1'b1, tail, tail});
      end
   endtask

   // expected output bytes for one accepted item
   task automatic frame_item(input stim_row_type it);
      logic [15:0] len;
      if (it.quiet || eos_sent) return;
      if (it.op == OP_END) begin
         rec_owed = 16'd0;
         len = (it.hdr_len >= 0) ? it.hdr_len[15:0] : 16'd0;
         queue_header(len, 1'b1);
         eos_sent = 1'b1;
         return;
      end
      if (rec_owed == 16'd0) begin
         if (it.count > 32'(MAX_RECORD_LENGTH)) len = MAX_RECORD_LENGTH;
         else len = it.count[15:0];
         if (len == 16'd0) len = 16'd1;
         if (it.hdr_len >= 0) len = it.hdr_len[15:0];
         queue_header(len, 1'b0);
         rec_owed = len;
      end
      framed_q.push_back(framed_byte_type'{it.data, 1'b0, 1'b1, 1'b0});
      rec_owed = rec_owed - 16'd1;
   endtask

   function automatic stim_row_type rand_item();
      stim_row_type r;
      r.op      = OP_DATA;
      r.data    = 8'($urandom_range(0, 255));
      r.hdr_len = NO_LEN;
      r.quiet   = 1'b0;
      // count is only read when a record opens; keep records short
      if (rec_owed != 16'd0) r.count = $urandom();
      else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: r.count = $urandom_range(0, 4);
            6, 7, 8: r.count = $urandom_range(5, 16);
            default: r.count = $urandom_range(17, 40);
         endcase
      end
      return r;
   endfunction

   task automatic send_item(input stim_row_type it);
      req_valid            <= 1'b1;
      req_opcode           <= it.op;
      req_data_byte        <= it.data;
      req_chunk_bytes_left <= it.count;
      do @(posedge clock); while (!req_ready);
      frame_item(it);
   endtask

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (framed_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_RECORD_ID;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_record_id(input logic [15:0] id);
      logic [31:0] rd_val;
      csr_access(1'b1, {16'd0, id}, rd_val);
      cur_req_id = id;
      csr_access(1'b0, 32'd0, rd_val);
      check_field("record_id", 32'(id), 32'(rd_val[15:0]));
   endtask

   task automatic random_phase();
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
         pace();
         send_item(rand_item());
      end
   endtask

   // receiver: always ready, random, or runs of stalls
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 2));
         mode_left  <= $urandom_range(16, 80);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         RDY_ALWAYS: rsp_ready <= 1'b1;
         RDY_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (hold_left == 0) begin
               rsp_ready <= ~rsp_ready;
               hold_left <= $urandom_range(0, 5);
            end else begin
               hold_left <= hold_left - 1;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (framed_q.size() == 0) begin
            $error("unexpected output transfer: out_byte %0h is_header %0b",
                   rsp_out_byte, rsp_is_header);
            err_count++;
         end else begin
            head_exp = framed_q.pop_front();
            check_field("out_byte", 32'(head_exp.out_byte), 32'(rsp_out_byte));
            check_field("is_header", 32'(head_exp.is_header), 32'(rsp_is_header));
            check_field("last", 32'(head_exp.last), 32'(rsp_last));
            check_field("stream_done", 32'(head_exp.stream_done),
                        32'(rsp_stream_done));
         end
      end
   end

   // watchdog on cycles with no transfer on any port
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [31:0] rd_val;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, 32'd0, rd_val);
      check_field("record_id", 32'(RECORD_ID_RESET), 32'(rd_val[15:0]));

      for (int i = 0; i < CLOSING_ROW; i++) begin
         pace();
         send_item(stim_table[i]);
      end
      drain();
      set_record_id(16'hffff);
      random_phase();
      drain();
      set_record_id(16'h0000);
      random_phase();
      drain();
      set_record_id(16'($urandom_range(2, 16'hfffe)));
      random_phase();

      // finish any open record so the clamp row opens a fresh one
      while (rec_owed != 16'd0) begin
         pace();
         send_item(rand_item());
      end
      for (int i = CLOSING_ROW; i < TABLE_ROWS; i++) begin
         pace();
         send_item(stim_table[i]);
      end
      drain();
      repeat (20) @(posedge clock);

      if (err_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### fcgi_stdin_record_framer.f
rtl/core/frf_pkg.sv
rtl/core/fcgi_stdin_record_framer.sv
bench/tb.sv
